// ----- hw/rtl/bwhm_pkg.sv -----
// Shared types and constants of the best-window Hamming match block.
// Depends on nothing; imported by bwhm_window and best_window_hamming_match_top.
`default_nettype none

package bwhm_pkg;

    // Item kinds carried in the request's user field.
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_GENOME  = 1'b1;

    // Three genomes are compared; the last one closes the run.
    localparam int          NUM_GENOMES = 3;
    localparam logic [1:0]  GENOME_LAST = 2'd2;

    // Popcount is split into groups of this many match bits.
    localparam int GROUP_BITS  = 8;
    localparam int GROUP_CNT_W = 4;

    // Result field widths.
    localparam int BEST_W = 7;
    localparam int MASK_W = 3;

    // Controls from the top level to the window and pattern registers.
    typedef struct packed {
        logic shift;        // a genome character enters the window
        logic pat_load;     // a pattern character is stored
        logic pat_restart;  // the stored pattern is discarded first
        logic stage_en;     // the pipeline advances
    } win_ctl_t;

    // Per-item information that travels along the scoring pipeline.
    typedef struct packed {
        logic [1:0] genome_id;
        logic       last;
        logic       clr;       // first character of a genome
        logic       win;       // a full window is present
        logic       len_diff;  // genome lengths differ after this item
    } tag_t;

    // One result as held in the output and skid registers.
    typedef struct packed {
        logic              status;
        logic [MASK_W-1:0] best_mask;
        logic [BEST_W-1:0] best_matches;
        logic [1:0]        genome_id;
        logic              final_report;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bwhm_window.sv -----
// Pattern and genome window shift registers with the parallel compare array.
// Depends on bwhm_pkg for the control struct.
`default_nettype none

module bwhm_window #(
    parameter int PATTERN_MAX = 64
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  bwhm_pkg::win_ctl_t        ctl,
    input  wire  [7:0]                character,
    output logic [PATTERN_MAX-1:0]    match_reg
);
    import bwhm_pkg::*;

    // The pattern is kept right-aligned so that entry k always faces window entry k.
    logic [7:0]             pat_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] pmask_reg;
    logic [PATTERN_MAX-1:0] pmask_next;
    logic [PATTERN_MAX-1:0] pmask_base;
    logic [7:0]             win_reg  [PATTERN_MAX];
    logic [7:0]             win_next [PATTERN_MAX];
    logic [7:0]             pat_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] match_next;

    // Shift the new character in at the top of both lines.
    always_comb begin
        pmask_base = ctl.pat_restart ? '0 : pmask_reg;
        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
            win_next[k]   = win_reg[k + 1];
            pat_next[k]   = pat_reg[k + 1];
            pmask_next[k] = pmask_base[k + 1];
        end
        win_next[PATTERN_MAX - 1]   = character;
        pat_next[PATTERN_MAX - 1]   = character;
        pmask_next[PATTERN_MAX - 1] = 1'b1;
    end

    // Compare every pattern position against the window that includes this character.
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            match_next[k] = pmask_reg[k] && (pat_reg[k] == win_next[k]);
        end
    end

    // The pattern valid mask is control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pmask_reg <= '0;
        end else if (ctl.pat_load) begin
            pmask_reg <= pmask_next;
        end
    end

    // Character lines and the registered match vector.
    always_ff @(posedge aclk) begin
        if (ctl.pat_load) begin
            pat_reg <= pat_next;
        end
        if (ctl.shift) begin
            win_reg <= win_next;
        end
        if (ctl.stage_en) begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/best_window_hamming_match_top.sv -----
// Top level of the best-window Hamming match block: item decode, genome
// bookkeeping, popcount pipeline, best-count tracking and output skid.
// Depends on bwhm_pkg and bwhm_window.
`default_nettype none

// The block accepts one character request per clock cycle while s_tready is
// high. Pattern characters (user opcode 0) build a right-aligned pattern of up
// to PATTERN_MAX bytes; genome characters (opcode 1) enter a window of the same
// depth, and every position is compared in parallel against the pattern. The
// match count is summed over two registered stages, so a genome's result leaves
// on m_* through the input, match, popcount and output registers, and a new
// character can be taken in every cycle that s_tready is high. The rate is set
// by the compare array and the eight-bit popcount groups, one pass per character.
// An output register plus a skid register keep s_tready registered; s_tready
// only drops while both hold a result. Genome lengths saturate at GENOME_LEN_MAX,
// and best_matches carries the low seven bits of the count.
module best_window_hamming_match_top #(
    parameter int PATTERN_MAX    = 64,
    parameter int GENOME_LEN_MAX = 65535
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Request channel.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] character
    input  wire  [2:0]  s_tuser,   // [0] opcode, [2:1] genome_index
    input  wire         s_tlast,   // last character of pattern or genome
    // Result channel.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [6:0] best_matches, [9:7] best_mask, [10] status
    output logic [1:0]  m_tuser,   // [1:0] genome_id
    output logic        m_tlast    // final_report
);
    import bwhm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int GW = $clog2(GENOME_LEN_MAX + 1);
    localparam int CW = (GW > LW) ? GW : LW;
    localparam int NG = (PATTERN_MAX + GROUP_BITS - 1) / GROUP_BITS;

    // Pipeline advance: everything moves unless the skid register is full.
    logic skid_valid_reg;
    logic adv;
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // Input register.
    logic       s0_valid_reg;
    logic       s0_op_reg;
    logic [7:0] s0_char_reg;
    logic [1:0] s0_g_reg;
    logic       s0_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_op_reg   <= s_tuser[0];
            s0_char_reg <= s_tdata;
            s0_g_reg    <= s_tuser[2:1];
            s0_last_reg <= s_tlast;
        end
    end

    // Pattern and genome bookkeeping state.
    logic [LW-1:0] plen_reg;
    logic          closed_reg;
    logic          open_reg;
    logic [GW-1:0] fill_reg;
    logic [GW-1:0] glen_reg [NUM_GENOMES];

    logic          is_pat;
    logic          is_gen;
    logic          start;
    logic [LW-1:0] plen_base;
    logic [LW-1:0] plen_next;
    logic [GW-1:0] fill_next;
    logic [GW-1:0] glen_base;
    logic [GW-1:0] glen_next [NUM_GENOMES];
    logic          win_ok;
    logic          len_diff;
    win_ctl_t      ctl;
    tag_t          s0_tag;

    function automatic logic [GW-1:0] sat_inc(input logic [GW-1:0] v);
        return (v < GW'(GENOME_LEN_MAX)) ? v + 1'b1 : v;
    endfunction

    // Decode the item and work out the state that follows it.
    always_comb begin
        is_pat    = s0_valid_reg && (s0_op_reg == OP_PATTERN);
        is_gen    = s0_valid_reg && (s0_op_reg == OP_GENOME) && (s0_g_reg <= GENOME_LAST);
        start     = !open_reg;

        plen_base = closed_reg ? '0 : plen_reg;
        ctl.pat_restart = closed_reg;
        ctl.pat_load    = adv && is_pat && (plen_base < LW'(PATTERN_MAX));
        ctl.shift       = adv && is_gen;
        ctl.stage_en    = adv;
        plen_next = ctl.pat_load ? plen_base + 1'b1 : plen_base;

        fill_next = sat_inc(start ? '0 : fill_reg);
        for (int k = 0; k < NUM_GENOMES; k++) begin
            if (2'(k) == s0_g_reg) begin
                glen_base    = start ? '0 : glen_reg[k];
                glen_next[k] = sat_inc(glen_base);
            end else begin
                glen_base    = glen_reg[k];
                glen_next[k] = glen_reg[k];
            end
        end

        win_ok   = (plen_reg != '0) && (CW'(fill_next) >= CW'(plen_reg));
        len_diff = (glen_next[0] != glen_next[1]) || (glen_next[1] != glen_next[2]);

        s0_tag.genome_id = s0_g_reg;
        s0_tag.last      = s0_last_reg;
        s0_tag.clr       = start;
        s0_tag.win       = win_ok;
        s0_tag.len_diff  = len_diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg   <= '0;
            closed_reg <= 1'b0;
            open_reg   <= 1'b0;
            fill_reg   <= '0;
            for (int k = 0; k < NUM_GENOMES; k++) begin
                glen_reg[k] <= '0;
            end
        end else if (adv) begin
            if (is_pat) begin
                plen_reg   <= plen_next;
                closed_reg <= s0_last_reg;
            end
            if (is_gen) begin
                open_reg <= !s0_last_reg;
                fill_reg <= fill_next;
                glen_reg <= glen_next;
            end
        end
    end

    // Window registers and compare array; the match vector is stage 1.
    logic [PATTERN_MAX-1:0] match_reg;

    bwhm_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .character (s0_char_reg),
        .match_reg (match_reg)
    );

    logic s1_valid_reg;
    tag_t s1_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= is_gen;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= s0_tag;
        end
    end

    // Stage 2: popcount of each group of match bits.
    logic [NG*GROUP_BITS-1:0] match_pad;
    logic [GROUP_CNT_W-1:0]   part_next [NG];
    logic [GROUP_CNT_W-1:0]   part_reg  [NG];
    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;

    assign match_pad = (NG*GROUP_BITS)'(match_reg);

    always_comb begin
        for (int i = 0; i < NG; i++) begin
            part_next[i] = '0;
            for (int j = 0; j < GROUP_BITS; j++) begin
                part_next[i] = part_next[i] + GROUP_CNT_W'(match_pad[i*GROUP_BITS + j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            part_reg   <= part_next;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Stage 3: total count, best-count update and result assembly.
    logic [LW-1:0] cnt;
    logic [LW-1:0] best_reg  [NUM_GENOMES];
    logic [LW-1:0] best_next [NUM_GENOMES];
    logic [LW-1:0] best_base;
    logic [LW-1:0] best_sel;
    logic [LW-1:0] best_top;
    logic [MASK_W-1:0] tie_mask;
    logic          is_final;
    logic          res_valid;
    res_t          res;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < NG; i++) begin
            cnt = cnt + LW'(part_reg[i]);
        end

        best_sel = '0;
        for (int k = 0; k < NUM_GENOMES; k++) begin
            if (2'(k) == s2_tag_reg.genome_id) begin
                best_base    = s2_tag_reg.clr ? '0 : best_reg[k];
                best_next[k] = (s2_tag_reg.win && (cnt > best_base)) ? cnt : best_base;
                best_sel     = best_next[k];
            end else begin
                best_base    = best_reg[k];
                best_next[k] = best_reg[k];
            end
        end

        best_top = best_next[0];
        if (best_next[1] > best_top) begin
            best_top = best_next[1];
        end
        if (best_next[2] > best_top) begin
            best_top = best_next[2];
        end
        for (int k = 0; k < NUM_GENOMES; k++) begin
            tie_mask[k] = (best_next[k] == best_top);
        end

        is_final  = (s2_tag_reg.genome_id == GENOME_LAST);
        res_valid = adv && s2_valid_reg && s2_tag_reg.last;

        res.genome_id    = s2_tag_reg.genome_id;
        res.best_matches = BEST_W'(best_sel);
        res.final_report = is_final;
        res.status       = is_final && s2_tag_reg.len_diff;
        res.best_mask    = (is_final && !s2_tag_reg.len_diff) ? tie_mask : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_GENOMES; k++) begin
                best_reg[k] <= '0;
            end
        end else if (adv && s2_valid_reg) begin
            best_reg <= best_next;
        end
    end

    // Output register with a skid register behind it.
    logic m_valid_reg;
    res_t m_res_reg;
    res_t skid_res_reg;
    logic m_fire;

    assign m_fire = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_fire) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                if (m_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    m_valid_reg <= 1'b1;
                end
            end else if (m_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                m_res_reg <= skid_res_reg;
            end
        end else if (res_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_res_reg <= res;
            end else begin
                m_res_reg <= res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.status, m_res_reg.best_mask, m_res_reg.best_matches};
    assign m_tuser  = m_res_reg.genome_id;
    assign m_tlast  = m_res_reg.final_report;

    // The skid register is only filled behind a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // A final report only closes the last genome.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == GENOME_LAST))
        else $error("final report for a genome other than the last");

    // A length mismatch reports an empty tie mask, and only on a final report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tlast && (m_tdata[9:7] == 3'b000)))
        else $error("length mismatch status with a tie mask or outside a final report");

    // A stalled result must not be replaced before it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_res_reg)))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire
